// ----- design/multi_camera_frame_aligner_macros.svh -----
// ----------------------------------------------------------------------------
// multi camera frame aligner assertion macros
// shared assertion shorthands for the aligner rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_CAMERA_FRAME_ALIGNER_MACROS_SVH
`define MULTI_CAMERA_FRAME_ALIGNER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MCFA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aligner assertion failed");
// next-cycle implication
`define MCFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aligner assertion failed");
`else
`define MCFA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MCFA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/mcfa_pkg.sv -----
// ----------------------------------------------------------------------------
// mcfa_pkg
// types and constants shared by the frame aligner modules
// ----------------------------------------------------------------------------
package mcfa_pkg;

   localparam int CAM_SLOTS  = 16;
   localparam int MAX_SET    = 16;
   localparam int OUT_DEPTH  = 4;
   localparam int CSR_IDX_W  = 3;

   localparam logic [1:0] POLICY_PASS  = 2'd0;
   localparam logic [1:0] POLICY_FRAME = 2'd1;
   localparam logic [1:0] POLICY_TIME  = 2'd2;

   localparam logic [1:0] TS_AUTO   = 2'd0;
   localparam logic [1:0] TS_HOST   = 2'd1;
   localparam logic [1:0] TS_DEVICE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_POLICY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TS_SOURCE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIFF    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BUF     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_MASK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_CAM    = 3'd5;

   typedef struct packed {
      logic [3:0]  camera_index;
      logic [63:0] frame_number;
      logic [63:0] host_time_ns;
      logic [63:0] device_time_ns;
      logic [15:0] frame_handle;
   } req_type;

   typedef struct packed {
      logic [31:0] group_id;
      logic [3:0]  member_camera;
      logic [15:0] member_handle;
      logic [63:0] member_frame_number;
      logic [63:0] member_sync_time;
      logic        last_of_set;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  sync_policy;
      logic [1:0]  timestamp_source;
      logic [63:0] max_timestamp_diff_ns;
      logic [3:0]  max_buffered_frames;
      logic [15:0] camera_mask;
      logic [3:0]  passthrough_camera;
   } cfg_type;

   typedef enum logic {
      CMD_PASS,
      CMD_SYNC
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   camera_index;
      logic [63:0]  frame_number;
      logic [63:0]  sync_time;
      logic [15:0]  frame_handle;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_PUSH,
      ST_CHECK,
      ST_FN_RD,
      ST_FN_EV,
      ST_DR_RD,
      ST_DR_EV,
      ST_DR_END,
      ST_TS_RD,
      ST_TS_EV,
      ST_TS_END,
      ST_EM_START,
      ST_EM_RD,
      ST_EM_EV
   } bk_state_type;

   typedef struct packed {
      logic busy;
   } bk_stat_type;

   typedef struct packed {
      logic full;
      logic empty;
   } oq_stat_type;

endpackage

// ----- design/mcfa_front.sv -----
// ----------------------------------------------------------------------------
// mcfa_front
// classifies incoming frame beats and queues commands for the back end
// ----------------------------------------------------------------------------
module mcfa_front import mcfa_pkg::*; #(
   parameter int MAX_CAMERAS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   localparam int LANES = (MAX_CAMERAS < CAM_SLOTS) ? MAX_CAMERAS : CAM_SLOTS;

   cmd_type   q_ff [2];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      take, keep;
   cmd_type   new_cmd;

   always_comb begin
      new_cmd.camera_index = req_data.camera_index;
      new_cmd.frame_number = req_data.frame_number;
      new_cmd.frame_handle = req_data.frame_handle;
      case (cfg.timestamp_source)
         TS_HOST:   new_cmd.sync_time = req_data.host_time_ns;
         TS_DEVICE: new_cmd.sync_time = req_data.device_time_ns;
         default:   new_cmd.sync_time = (req_data.host_time_ns != 64'd0) ?
                                        req_data.host_time_ns : req_data.device_time_ns;
      endcase
      keep = 1'b0;
      new_cmd.kind = CMD_SYNC;
      case (cfg.sync_policy)
         POLICY_PASS: begin
            new_cmd.kind = CMD_PASS;
            keep = (req_data.camera_index == cfg.passthrough_camera);
         end
         POLICY_FRAME, POLICY_TIME: begin
            keep = ({1'b0, req_data.camera_index} < 5'(LANES)) &&
                   cfg.camera_mask[req_data.camera_index];
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign take      = req_push && !req_full && keep;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ take;
      rp_in  = rp_ff ^ (cmd_pop && cmd_valid);
      cnt_in = cnt_ff + {1'b0, take} - {1'b0, cmd_pop && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         q_ff[wp_ff] <= new_cmd;
      end
   end

endmodule

// ----- design/mcfa_back.sv -----
// ----------------------------------------------------------------------------
// mcfa_back
// per-camera frame queues and the matching sequencer
// ----------------------------------------------------------------------------
module mcfa_back import mcfa_pkg::*; #(
   parameter int MAX_CAMERAS = 16,
   parameter int FIFO_DEPTH  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   input  logic        out_full,
   output logic        out_push,
   output rsp_type     out_data,
   output bk_stat_type stat
);

   localparam int LANES = (MAX_CAMERAS < CAM_SLOTS) ? MAX_CAMERAS : CAM_SLOTS;
   localparam int LW    = $clog2(LANES);
   localparam int PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW    = $clog2(FIFO_DEPTH + 1);
   localparam int XW    = ((CW > 4) ? CW : 4) + 1;
   localparam int AW    = $clog2(LANES * FIFO_DEPTH);
   localparam int ENTRIES = LANES * FIFO_DEPTH;

   typedef struct packed {
      logic [63:0] fn;
      logic [63:0] ts;
      logic [15:0] handle;
   } entry_type;

   bk_state_type state_ff, state_in;
   logic [LW-1:0] ci_ff, ci_in, lo_cam_ff, lo_cam_in;
   cmd_type       cmd_ff, cmd_in;
   logic [63:0]   target_ff, target_in, lo_ff, lo_in, hi_ff, hi_in;
   logic          have_ff, have_in, dropped_ff, dropped_in;
   logic [4:0]    n_ff, n_in;
   logic [31:0]   gid_ff, gid_in;

   logic [PW-1:0] rp_ff [LANES];
   logic [CW-1:0] cnt_ff [LANES];

   entry_type     mem [ENTRIES];
   entry_type     rd_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr, wr_addr;

   logic [LANES-1:0] req_mask;
   logic          all_ready, lane_last, last_member;
   logic [5:0]    members;
   logic [LW-1:0] push_lane, pop_lane;
   logic          push_en, pop_en;
   logic [PW-1:0] push_rp;
   logic [CW-1:0] push_cnt;
   logic [XW-1:0] depth_x, lim, c0, c1, r0x, r1x, slot;

   assign req_mask = cfg.camera_mask[LANES-1:0];
   assign members  = 6'($countones(req_mask));
   assign lane_last = (ci_ff == LW'(LANES - 1));
   assign last_member = ((req_mask >> ci_ff) >> 1) == '0;
   assign stat.busy = (state_ff != ST_IDLE);

   always_comb begin
      all_ready = |req_mask;
      for (int l = 0; l < LANES; l++) begin
         if (req_mask[l] && cnt_ff[l] == '0) all_ready = 1'b0;
      end
   end

   // push with drop-oldest and trim to the configured limit
   always_comb begin
      push_lane = cmd_ff.camera_index[LW-1:0];
      depth_x   = XW'(FIFO_DEPTH);
      lim = (cfg.max_buffered_frames == 4'd0 ||
             XW'(cfg.max_buffered_frames) > depth_x) ? depth_x
                                                     : XW'(cfg.max_buffered_frames);
      c0  = XW'(cnt_ff[push_lane]);
      r0x = XW'(rp_ff[push_lane]);
      if (c0 >= depth_x) begin
         r0x = r0x + XW'(1);
         if (r0x == depth_x) r0x = '0;
         c0 = depth_x - XW'(1);
      end
      slot = r0x + c0;
      if (slot >= depth_x) slot = slot - depth_x;
      c1  = c0 + XW'(1);
      r1x = r0x;
      if (c1 > lim) begin
         r1x = r0x + (c1 - lim);
         if (r1x >= depth_x) r1x = r1x - depth_x;
         c1 = lim;
      end
      push_rp  = PW'(r1x);
      push_cnt = CW'(c1);
      wr_addr  = AW'(push_lane) * AW'(FIFO_DEPTH) + AW'(slot);
      rd_addr  = AW'(ci_ff) * AW'(FIFO_DEPTH) + AW'(rp_ff[ci_ff]);
   end

   always_comb begin
      state_in   = state_ff;
      ci_in      = ci_ff;
      cmd_in     = cmd_ff;
      target_in  = target_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      lo_cam_in  = lo_cam_ff;
      have_in    = have_ff;
      dropped_in = dropped_ff;
      n_in       = n_ff;
      gid_in     = gid_ff;
      cmd_pop    = 1'b0;
      rd_en      = 1'b0;
      push_en    = 1'b0;
      pop_en     = 1'b0;
      pop_lane   = ci_ff;
      out_push   = 1'b0;
      out_data.group_id            = gid_ff;
      out_data.member_camera       = 4'(ci_ff);
      out_data.member_handle       = rd_ff.handle;
      out_data.member_frame_number = rd_ff.fn;
      out_data.member_sync_time    = rd_ff.ts;
      out_data.last_of_set         = last_member;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               n_in    = '0;
               state_in = (cmd.kind == CMD_PASS) ? ST_PASS : ST_PUSH;
            end
         end
         ST_PASS: begin
            out_data.member_camera       = cmd_ff.camera_index;
            out_data.member_handle       = cmd_ff.frame_handle;
            out_data.member_frame_number = cmd_ff.frame_number;
            out_data.member_sync_time    = cmd_ff.sync_time;
            out_data.last_of_set         = 1'b1;
            if (!out_full) begin
               out_push = 1'b1;
               gid_in   = gid_ff + 32'd1;
               state_in = ST_IDLE;
            end
         end
         ST_PUSH: begin
            push_en  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            ci_in = '0;
            if (!all_ready) begin
               state_in = ST_IDLE;
            end else if (cfg.sync_policy == POLICY_FRAME) begin
               target_in = '0;
               state_in  = ST_FN_RD;
            end else begin
               have_in  = 1'b0;
               hi_in    = '0;
               state_in = ST_TS_RD;
            end
         end
         // largest front frame number
         ST_FN_RD: begin
            if (req_mask[ci_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_FN_EV;
            end else if (lane_last) begin
               ci_in = '0; dropped_in = 1'b0; state_in = ST_DR_RD;
            end else begin
               ci_in = ci_ff + LW'(1);
            end
         end
         ST_FN_EV: begin
            if (rd_ff.fn > target_ff) target_in = rd_ff.fn;
            if (lane_last) begin
               ci_in = '0; dropped_in = 1'b0; state_in = ST_DR_RD;
            end else begin
               ci_in = ci_ff + LW'(1); state_in = ST_FN_RD;
            end
         end
         // drop fronts below the target
         ST_DR_RD: begin
            if (req_mask[ci_ff] && cnt_ff[ci_ff] != '0) begin
               rd_en    = 1'b1;
               state_in = ST_DR_EV;
            end else if (lane_last) begin
               state_in = ST_DR_END;
            end else begin
               ci_in = ci_ff + LW'(1);
            end
         end
         ST_DR_EV: begin
            if (rd_ff.fn < target_ff) begin
               pop_en     = 1'b1;
               dropped_in = 1'b1;
               state_in   = ST_DR_RD;
            end else if (lane_last) begin
               state_in = ST_DR_END;
            end else begin
               ci_in = ci_ff + LW'(1); state_in = ST_DR_RD;
            end
         end
         ST_DR_END: begin
            ci_in = '0;
            if (!all_ready) begin
               state_in = ST_IDLE;
            end else if (dropped_ff) begin
               target_in = '0;
               state_in  = ST_FN_RD;
            end else begin
               state_in = ST_EM_START;
            end
         end
         // front timestamp spread
         ST_TS_RD: begin
            if (req_mask[ci_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_TS_EV;
            end else if (lane_last) begin
               state_in = ST_TS_END;
            end else begin
               ci_in = ci_ff + LW'(1);
            end
         end
         ST_TS_EV: begin
            if (!have_ff || rd_ff.ts < lo_ff) begin
               lo_in = rd_ff.ts; lo_cam_in = ci_ff; have_in = 1'b1;
            end
            if (rd_ff.ts > hi_ff) hi_in = rd_ff.ts;
            if (lane_last) begin
               state_in = ST_TS_END;
            end else begin
               ci_in = ci_ff + LW'(1); state_in = ST_TS_RD;
            end
         end
         ST_TS_END: begin
            if (hi_ff - lo_ff <= cfg.max_timestamp_diff_ns) begin
               state_in = ST_EM_START;
            end else begin
               pop_en   = 1'b1;
               pop_lane = lo_cam_ff;
               state_in = ST_CHECK;
            end
         end
         // emit one set, if it fits this step
         ST_EM_START: begin
            ci_in = '0;
            if (6'(n_ff) + members > 6'(MAX_SET)) state_in = ST_IDLE;
            else state_in = ST_EM_RD;
         end
         ST_EM_RD: begin
            if (req_mask[ci_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_EM_EV;
            end else if (lane_last) begin
               gid_in = gid_ff + 32'd1; n_in = n_ff + 5'(members); state_in = ST_CHECK;
            end else begin
               ci_in = ci_ff + LW'(1);
            end
         end
         ST_EM_EV: begin
            if (!out_full) begin
               out_push = 1'b1;
               pop_en   = 1'b1;
               if (last_member) begin
                  gid_in = gid_ff + 32'd1; n_in = n_ff + 5'(members); state_in = ST_CHECK;
               end else begin
                  ci_in = ci_ff + LW'(1); state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gid_ff   <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         gid_ff   <= gid_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff      <= ci_in;
      cmd_ff     <= cmd_in;
      target_ff  <= target_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lo_cam_ff  <= lo_cam_in;
      have_ff    <= have_in;
      dropped_ff <= dropped_in;
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (reset) begin
            rp_ff[l]  <= '0;
            cnt_ff[l] <= '0;
         end else if (push_en && push_lane == LW'(l)) begin
            rp_ff[l]  <= push_rp;
            cnt_ff[l] <= push_cnt;
         end else if (pop_en && pop_lane == LW'(l)) begin
            rp_ff[l]  <= (({1'b0, rp_ff[l]} + (PW+1)'(1)) == (PW+1)'(FIFO_DEPTH)) ?
                         '0 : rp_ff[l] + PW'(1);
            cnt_ff[l] <= cnt_ff[l] - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[wr_addr] <= '{fn: cmd_ff.frame_number, ts: cmd_ff.sync_time,
                           handle: cmd_ff.frame_handle};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- design/mcfa_out_queue.sv -----
// ----------------------------------------------------------------------------
// mcfa_out_queue
// result queue between the sequencer and the result port
// ----------------------------------------------------------------------------
module mcfa_out_queue import mcfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  rsp_type     push_data,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output rsp_type     rsp_data,
   output oq_stat_type stat
);

   localparam int QW = $clog2(OUT_DEPTH);

   rsp_type       q_ff [OUT_DEPTH];
   logic [QW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign stat.full  = (cnt_ff == (QW+1)'(OUT_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign rsp_empty  = stat.empty;
   assign rsp_data   = q_ff[rp_ff];
   assign do_push    = push && !stat.full;
   assign do_pop     = rsp_pop && !stat.empty;

   always_comb begin
      wp_in  = wp_ff + QW'(do_push);
      rp_in  = rp_ff + QW'(do_pop);
      cnt_in = cnt_ff + (QW+1)'(do_push) - (QW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= push_data;
      end
   end

endmodule

// ----- design/multi_camera_frame_aligner.sv -----
// ----------------------------------------------------------------------------
// multi_camera_frame_aligner
// aligns frame descriptors from several cameras into matched sets
// ----------------------------------------------------------------------------
// channel   ports                              beat
// request   req_push, req_full, req_data       one frame descriptor
// response  rsp_empty, rsp_pop, rsp_data       one set member
// config    csr_wr_en, csr_index, csr_wdata    one register write
//
// a pass-through frame goes straight from the command queue to the result
// queue; a synchronized frame is pushed into its camera queue, then walks all
// camera lanes once per front scan, drop and emit pass, with a read of the
// single-port frame memory for each required lane and each dropped front.
// reset is synchronous and leaves all camera queues empty; no clearing pass.
// a full response queue stalls the sequencer; a two-deep command queue
// lets the request side run ahead of it.
// ----------------------------------------------------------------------------
`include "multi_camera_frame_aligner_macros.svh"

module multi_camera_frame_aligner import mcfa_pkg::*; #(
   parameter int MAX_CAMERAS = 16,
   parameter int FIFO_DEPTH  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        cmd_valid, cmd_pop, out_push;
   cmd_type     cmd;
   rsp_type     out_data;
   bk_stat_type bk_stat;
   oq_stat_type oq_stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC_POLICY: cfg_in.sync_policy           = csr_wdata[1:0];
            CSR_TS_SOURCE:   cfg_in.timestamp_source      = csr_wdata[1:0];
            CSR_MAX_DIFF:    cfg_in.max_timestamp_diff_ns = csr_wdata;
            CSR_MAX_BUF:     cfg_in.max_buffered_frames   = csr_wdata[3:0];
            CSR_CAM_MASK:    cfg_in.camera_mask           = csr_wdata[15:0];
            CSR_PASS_CAM:    cfg_in.passthrough_camera    = csr_wdata[3:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sync_policy: POLICY_PASS, timestamp_source: TS_AUTO,
                     max_timestamp_diff_ns: 64'd0, max_buffered_frames: 4'd0,
                     camera_mask: 16'd1, passthrough_camera: 4'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcfa_front #(.MAX_CAMERAS(MAX_CAMERAS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   mcfa_back #(.MAX_CAMERAS(MAX_CAMERAS), .FIFO_DEPTH(FIFO_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .out_full  (oq_stat.full),
      .out_push  (out_push),
      .out_data  (out_data),
      .stat      (bk_stat)
   );

   mcfa_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .stat      (oq_stat)
   );

   // the sequencer never writes a full result queue
   `MCFA_ASSERT_IMPLIES(a_no_out_overflow, clock, reset, out_push, !oq_stat.full)
   // a command is taken only by an idle sequencer, which then leaves idle
   `MCFA_ASSERT_NEXT(a_cmd_starts_work, clock, reset, cmd_pop, bk_stat.busy)
   // reset leaves the sequencer idle
   `MCFA_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !bk_stat.busy)

endmodule

// ----- bench/multi_camera_frame_aligner_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi camera frame aligner testbench
// drives frame descriptors through every sync policy and register,
// predicts the emitted set members and checks each response beat in order
// ----------------------------------------------------------------------------
module multi_camera_frame_aligner_tb;
   import mcfa_pkg::*;

   localparam int LANES = 16;
   localparam int DEPTH = 8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 400;
   localparam logic [1:0] POLICY_UNUSED = 2'd3;
   localparam logic [1:0] TS_UNUSED     = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   req_type              req_data;
   logic                 rsp_empty;
   logic                 rsp_pop;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wdata;

   multi_camera_frame_aligner u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [1:0]  pol;
   logic [1:0]  ts_src;
   logic [63:0] max_diff;
   logic [3:0]  max_buf;
   logic [15:0] cam_mask;
   logic [3:0]  pass_cam;
   logic [63:0] q_fn   [LANES][DEPTH];
   logic [63:0] q_ts   [LANES][DEPTH];
   logic [15:0] q_hdl  [LANES][DEPTH];
   int          q_rd   [LANES];
   int          q_cnt  [LANES];
   logic [31:0] group_seq;

   rsp_type expected_members[$];
   int      mismatch_count;
   int      idle_cycles;
   bit      hold_rsp;
   int      burst_left;
   bit      push_held;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      mismatch_count++;
   endtask

   // ---------------- predictor ----------------
   function automatic void append_member(rsp_type m);
      expected_members = {expected_members, m};
   endfunction

   function automatic bit lane_needed(int c);
      return cam_mask[c];
   endfunction

   function automatic bit fronts_ready();
      bit any;
      any = 0;
      for (int c = 0; c < LANES; c++) begin
         if (!lane_needed(c)) continue;
         if (q_cnt[c] == 0) return 0;
         any = 1;
      end
      return any;
   endfunction

   function automatic void drop_front(int c);
      if (q_cnt[c] == 0) return;
      q_rd[c] = (q_rd[c] + 1) % DEPTH;
      q_cnt[c]--;
   endfunction

   function automatic bit emit_set(ref int used);
      int members, done;
      rsp_type m;
      members = $countones(cam_mask);
      done = 0;
      if (used + members > MAX_SET) return 0;
      for (int c = 0; c < LANES; c++) begin
         if (!lane_needed(c)) continue;
         done++;
         m.group_id = group_seq;
         m.member_camera = c[3:0];
         m.member_handle = q_hdl[c][q_rd[c]];
         m.member_frame_number = q_fn[c][q_rd[c]];
         m.member_sync_time = q_ts[c][q_rd[c]];
         m.last_of_set = (done == members);
         append_member(m);
         used++;
         drop_front(c);
      end
      group_seq++;
      return 1;
   endfunction

   function automatic void predict_frame(req_type f);
      int c, lim, slot, used, lo_cam;
      logic [63:0] ts, target, lo, hi, t;
      bit dropped, have;
      rsp_type m;
      c = int'(f.camera_index);
      used = 0;
      if (ts_src == TS_HOST) ts = f.host_time_ns;
      else if (ts_src == TS_DEVICE) ts = f.device_time_ns;
      else ts = (f.host_time_ns != 0) ? f.host_time_ns : f.device_time_ns;
      if (pol == POLICY_PASS) begin
         if (f.camera_index != pass_cam) return;
         m.group_id = group_seq;
         m.member_camera = f.camera_index;
         m.member_handle = f.frame_handle;
         m.member_frame_number = f.frame_number;
         m.member_sync_time = ts;
         m.last_of_set = 1'b1;
         append_member(m);
         group_seq++;
         return;
      end
      if (pol != POLICY_FRAME && pol != POLICY_TIME) return;
      if (!lane_needed(c)) return;
      lim = int'(max_buf);
      if (lim == 0 || lim > DEPTH) lim = DEPTH;
      if (q_cnt[c] >= DEPTH) drop_front(c);
      slot = (q_rd[c] + q_cnt[c]) % DEPTH;
      q_fn[c][slot] = f.frame_number;
      q_ts[c][slot] = ts;
      q_hdl[c][slot] = f.frame_handle;
      q_cnt[c]++;
      while (q_cnt[c] > lim) drop_front(c);
      if (pol == POLICY_FRAME) begin
         while (fronts_ready()) begin
            target = 0;
            dropped = 0;
            for (int k = 0; k < LANES; k++)
               if (lane_needed(k) && q_fn[k][q_rd[k]] > target) target = q_fn[k][q_rd[k]];
            for (int k = 0; k < LANES; k++) begin
               if (!lane_needed(k)) continue;
               while (q_cnt[k] != 0 && q_fn[k][q_rd[k]] < target) begin
                  drop_front(k);
                  dropped = 1;
               end
            end
            if (!fronts_ready()) return;
            if (dropped) continue;
            if (!emit_set(used)) return;
         end
      end else begin
         while (fronts_ready()) begin
            lo = '1;
            hi = 0;
            lo_cam = 0;
            have = 0;
            for (int k = 0; k < LANES; k++) begin
               if (!lane_needed(k)) continue;
               t = q_ts[k][q_rd[k]];
               if (!have || t < lo) begin
                  lo = t;
                  lo_cam = k;
                  have = 1;
               end
               if (t > hi) hi = t;
            end
            if (hi - lo <= max_diff) begin
               if (!emit_set(used)) return;
            end else begin
               drop_front(lo_cam);
            end
         end
      end
   endfunction

   // ---------------- drivers ----------------
   // lower push at the current falling edge if a burst left it high
   task automatic stop_sender();
      if (push_held) req_push <= 1'b0;
      push_held = 0;
      burst_left = 0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      stop_sender();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SYNC_POLICY: pol = value[1:0];
         CSR_TS_SOURCE:   ts_src = value[1:0];
         CSR_MAX_DIFF:    max_diff = value;
         CSR_MAX_BUF:     max_buf = value[3:0];
         CSR_CAM_MASK:    cam_mask = value[15:0];
         CSR_PASS_CAM:    pass_cam = value[3:0];
         default: ;
      endcase
   endtask

   // sender: bursts with random gaps; caller is at a falling edge
   // push stays high between beats of a burst
   task automatic send_frame(input req_type f);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            if (push_held) req_push <= 1'b0;
            push_held = 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      push_held = 1;
      req_data <= f;
      do @(posedge clock); while (req_full);
      predict_frame(f);
      @(negedge clock);
   endtask

   task automatic drain();
      stop_sender();
      while (expected_members.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic req_type make_frame(int c, logic [63:0] fn, logic [63:0] ts);
      req_type f;
      f.camera_index = c[3:0];
      f.frame_number = fn;
      f.host_time_ns = ($urandom_range(0, 3) == 0) ? 64'd0 : ts;
      f.device_time_ns = ts + 64'($urandom_range(0, 50));
      f.frame_handle = 16'($urandom);
      return f;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type rand_frame();
      req_type f;
      f.camera_index = 4'($urandom_range(0, 15));
      f.frame_number = rand64();
      f.host_time_ns = rand64();
      f.device_time_ns = rand64();
      f.frame_handle = 16'($urandom);
      return f;
   endfunction

   // ---------------- tests ----------------
   task automatic test_passthrough();
      req_type f;
      write_reg(CSR_SYNC_POLICY, 64'(POLICY_PASS));
      write_reg(CSR_PASS_CAM, 64'd15);
      for (int k = 0; k < 4; k++) begin
         f = rand_frame();
         if (k < 2) f.camera_index = 4'd15;
         if (k == 0) begin
            f.frame_number = '1;
            f.host_time_ns = '0;
            f.device_time_ns = '1;
            f.frame_handle = '1;
         end
         send_frame(f);
      end
      drain();
   endtask

   task automatic test_unused_policy();
      write_reg(CSR_SYNC_POLICY, 64'(POLICY_UNUSED));
      for (int k = 0; k < 3; k++) send_frame(rand_frame());
      drain();
   endtask

   task automatic test_frame_directed();
      write_reg(CSR_SYNC_POLICY, 64'(POLICY_FRAME));
      write_reg(CSR_TS_SOURCE, 64'(TS_HOST));
      write_reg(CSR_CAM_MASK, 64'h0003);
      write_reg(CSR_MAX_BUF, 64'd0);
      send_frame(make_frame(0, 64'd5, 64'd100));
      send_frame(make_frame(0, 64'd6, 64'd200));
      send_frame(make_frame(1, 64'd6, 64'd210));   // drops 5, emits 6
      send_frame(make_frame(2, 64'd6, 64'd210));   // unrequired camera
      send_frame(make_frame(1, 64'd7, 64'd300));
      send_frame(make_frame(0, '1, '1));
      drain();
      // empty mask ignores everything
      write_reg(CSR_CAM_MASK, 64'h0000);
      send_frame(make_frame(0, 64'd9, 64'd9));
      drain();
   endtask

   task automatic test_timestamp_directed();
      write_reg(CSR_SYNC_POLICY, 64'(POLICY_TIME));
      write_reg(CSR_TS_SOURCE, 64'(TS_DEVICE));
      write_reg(CSR_MAX_DIFF, 64'd20);
      write_reg(CSR_MAX_BUF, 64'd15);              // saturates to full depth
      write_reg(CSR_CAM_MASK, 64'h8001);
      send_frame(make_frame(15, 64'd1, 64'd1000));
      send_frame(make_frame(0, 64'd1, 64'd1000)); // same base time; lane 0 wins a tie for the lowest front
      send_frame(make_frame(0, 64'd2, 64'd1010));
      send_frame(make_frame(15, 64'd2, 64'd5000));
      drain();
      write_reg(CSR_TS_SOURCE, 64'(TS_UNUSED));    // acts as auto
      write_reg(CSR_MAX_DIFF, '1);
      send_frame(make_frame(0, 64'd3, 64'd7));
      drain();
   endtask

   task automatic test_full_mask();
      // all sixteen lanes: one set reaches the MAX_SET member limit
      write_reg(CSR_SYNC_POLICY, 64'(POLICY_FRAME));
      write_reg(CSR_TS_SOURCE, 64'(TS_AUTO));
      write_reg(CSR_CAM_MASK, 64'hffff);
      write_reg(CSR_MAX_BUF, 64'd1);
      for (int c = 0; c < LANES; c++) send_frame(make_frame(c, 64'd42, 64'd1));
      drain();
   endtask

   // long receiver hold-off while the sender keeps going
   task automatic test_backpressure();
      write_reg(CSR_SYNC_POLICY, 64'(POLICY_PASS));
      write_reg(CSR_PASS_CAM, 64'd3);
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         for (int k = 0; k < 12; k++) begin
            req_type f;
            f = rand_frame();
            f.camera_index = 4'd3;
            send_frame(f);
         end
      join
      drain();
   endtask

   task automatic test_random_sync(input logic [1:0] p, input int items);
      logic [15:0] mask;
      logic [63:0] fn_base, ts_base;
      int c;
      mask = ($urandom_range(0, 1)) ? 16'h0007 : (16'h1 << $urandom_range(0, 15))
             | 16'h0100;
      write_reg(CSR_SYNC_POLICY, 64'(p));
      write_reg(CSR_TS_SOURCE, 64'($urandom_range(0, 3)));
      write_reg(CSR_MAX_DIFF, 64'($urandom_range(0, 40)));
      write_reg(CSR_MAX_BUF, 64'($urandom_range(0, 9)));
      write_reg(CSR_CAM_MASK, 64'(mask));
      write_reg(CSR_PASS_CAM, 64'($urandom_range(0, 15)));
      fn_base = rand64() >> 2;
      ts_base = rand64() >> 2;
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_frame(rand_frame());
         end else begin
            do c = int'($urandom_range(0, 15)); while (!mask[c]);
            // mostly aligned frames, with some skew and gaps
            send_frame(make_frame(c, fn_base + 64'(k / 3) + 64'($urandom_range(0, 1)),
                                  ts_base + 64'(k / 3) * 64'd100 +
                                  64'($urandom_range(0, 30))));
         end
      end
      drain();
   endtask

   // ---------------- receiver and checker ----------------
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_pop <= 1'b0;
         else if (($time / 64) % 4 == 0) rsp_pop <= 1'b1;
         else rsp_pop <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_members.size() == 0) begin
            report_mismatch("unexpected beat", 64'(rsp_data.member_handle), 64'd0);
         end else begin
            want = expected_members[0];
            expected_members.delete(0);
            if (rsp_data.group_id !== want.group_id)
               report_mismatch("group_id", 64'(rsp_data.group_id), 64'(want.group_id));
            if (rsp_data.member_camera !== want.member_camera)
               report_mismatch("member_camera", 64'(rsp_data.member_camera),
                               64'(want.member_camera));
            if (rsp_data.member_handle !== want.member_handle)
               report_mismatch("member_handle", 64'(rsp_data.member_handle),
                               64'(want.member_handle));
            if (rsp_data.member_frame_number !== want.member_frame_number)
               report_mismatch("member_frame_number", rsp_data.member_frame_number,
                               want.member_frame_number);
            if (rsp_data.member_sync_time !== want.member_sync_time)
               report_mismatch("member_sync_time", rsp_data.member_sync_time,
                               want.member_sync_time);
            if (rsp_data.last_of_set !== want.last_of_set)
               report_mismatch("last_of_set", 64'(rsp_data.last_of_set),
                               64'(want.last_of_set));
         end
      end
   end

   // watchdog on cycles with no accepted beat or register write
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      hold_rsp = 0;
      burst_left = 0;
      push_held = 0;
      pol = POLICY_PASS;
      ts_src = TS_AUTO;
      max_diff = '0;
      max_buf = '0;
      cam_mask = 16'h0001;
      pass_cam = '0;
      group_seq = '0;
      for (int c = 0; c < LANES; c++) begin
         q_rd[c] = 0;
         q_cnt[c] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_passthrough();
      test_unused_policy();
      test_frame_directed();
      test_timestamp_directed();
      test_full_mask();
      test_backpressure();
      test_random_sync(POLICY_FRAME, 15);
      test_random_sync(POLICY_TIME, 15);
      test_random_sync(POLICY_FRAME, 12);
      test_random_sync(POLICY_TIME, 12);
      test_random_sync(POLICY_PASS, 8);

      if (mismatch_count == 0 && expected_members.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/mcfa_pkg.sv
design/mcfa_front.sv
design/mcfa_back.sv
design/mcfa_out_queue.sv
design/multi_camera_frame_aligner.sv
bench/multi_camera_frame_aligner_tb.sv
